[design/spr_pkg.sv]
// Package for the segment placement ranker: types, constants, codes.
// No dependencies; used by the core (spr_divider uses no package items).
`default_nettype none
package spr_pkg;
   // table depth; port widths for segment index and counts are sized for it
   localparam int NUM_SEGMENTS = 8;
   localparam logic [1:0] REQ_SET_CAP  = 2'd0;
   localparam logic [1:0] REQ_ADD_FREE = 2'd1;
   localparam logic [1:0] REQ_PLACE    = 2'd2;
   localparam logic CSR_ACTIVE = 1'b0;
   localparam logic CSR_POLICY = 1'b1;
   localparam int WEIGHT_CONTIG = 45875;
   localparam int WEIGHT_FREE   = 19661;
   localparam int WEIGHT_BITS   = 16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV_FREE, ST_DIV_CONTIG, ST_MUL, ST_RANK, ST_SCAN, ST_DONE
   } state_type;
endpackage
`default_nettype wire

[design/spr_divider.sv]
// Shared restoring divider: floor(num * 2^FRAC / den), saturated, one bit per cycle.
// Uses no package items. A zero divisor gives a zero quotient.
`default_nettype none
module spr_divider #(
   parameter int SIZE_BITS = 40,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SIZE_BITS-1:0] num,
   input  wire logic [SIZE_BITS-1:0] den,
   output logic                      done,
   output logic [FRAC_BITS-1:0]      quot
);
   localparam int CW = $clog2(FRAC_BITS + 1);
   logic [SIZE_BITS:0]   rem_ff, rem_in;
   logic [SIZE_BITS-1:0] den_ff, den_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 run_ff, run_in, done_ff, done_in;
   logic [SIZE_BITS:0]   shifted;

   always_comb begin
      rem_in = rem_ff; den_in = den_ff; q_in = q_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      shifted = {rem_ff[SIZE_BITS-1:0], 1'b0};
      if (start) begin
         den_in = den; rem_in = {1'b0, num}; cnt_in = '0; q_in = '0;
         if (den == '0) begin
            done_in = 1'b1;
         end else if (num >= den) begin
            q_in = '1; done_in = 1'b1;
         end else begin
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            q_in = {q_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(FRAC_BITS - 1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[design/segment_placement_ranker_core.sv]
// Segment placement ranker top level: segment tables, sequencer, ranking.
// Depends on spr_pkg and spr_divider.
// Load transaction: taken on accept, busy never rises; the next start can follow at once.
// Placement transaction: per segment two divisions on the shared divider plus a
// multiply step, then a selection ranking over the segments, a fit scan along the
// ranking that stops at the first fit, and an output state (ST_DONE).
// busy stays high meanwhile; one transaction at a time.
// Result strobe lasts one cycle and cannot be stalled; a new start is taken in that cycle.
// Synchronous reset clears segment entries and sequencer; active and policy reset to 1.
`default_nettype none
module segment_placement_ranker_core #(
   parameter int SIZE_BITS       = 40,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_type,
   input  wire logic [2:0]           req_segment_index,
   input  wire logic [SIZE_BITS-1:0] req_amount,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [3:0]           csr_data,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_chosen_segment,
   output logic                      rsp_primary_fits,
   output logic                      rsp_eventual_fits,
   output logic [3:0]                rsp_attempts_made,
   output logic [3:0]                rsp_fallback_count,
   output logic [3:0]                rsp_ranked_count
);
   localparam int NUM_SEGMENTS = spr_pkg::NUM_SEGMENTS;
   localparam int SW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int NW = $clog2(NUM_SEGMENTS + 1);
   localparam int F  = RATIO_FRAC_BITS;
   localparam int SCW = F + spr_pkg::WEIGHT_BITS + 1;
   localparam logic [SIZE_BITS-1:0] SMAX = '1;

   // segment tables, cleared at reset (8 entries by default)
   logic [SIZE_BITS-1:0] cap_ff [NUM_SEGMENTS];
   logic [SIZE_BITS-1:0] tot_ff [NUM_SEGMENTS];
   logic [SIZE_BITS-1:0] lrg_ff [NUM_SEGMENTS];
   // per-request scratch: free ratio, weighted score, ranking order
   logic [F-1:0]   fr_ff   [NUM_SEGMENTS];
   logic [F-1:0]   ct_ff;
   logic [SCW-1:0] sc_ff   [NUM_SEGMENTS];
   logic [SW-1:0]  ord_ff  [NUM_SEGMENTS];
   logic [NUM_SEGMENTS-1:0] used_ff;

   logic [3:0] active_ff;
   logic       policy_ff;
   spr_pkg::state_type state_ff, state_in;
   logic [SIZE_BITS-1:0] amt_ff;
   logic [NW-1:0] n_ff, i_ff, j_ff, pos_ff;
   logic [SW-1:0] best_ff;
   logic          have_ff;
   logic          evt_ff;
   logic [NW-1:0] att_ff;

   logic          div_start;
   logic [SIZE_BITS-1:0] div_num, div_den;
   logic          div_done;
   logic [F-1:0]  div_q;

   spr_divider #(.SIZE_BITS(SIZE_BITS), .FRAC_BITS(F)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q));

   // effective active count: 0 reads as 1, clamp to table depth
   logic [NW-1:0] n_eff;
   always_comb begin
      if (active_ff == 4'd0) n_eff = NW'(1);
      else if (32'(active_ff) > NUM_SEGMENTS) n_eff = NW'(NUM_SEGMENTS);
      else n_eff = NW'(active_ff);
   end

   logic [SW-1:0] ci, cb;
   assign ci = i_ff[SW-1:0];
   assign cb = best_ff;

   // compare: candidate ci ranks strictly before current best cb
   logic fit_c, fit_b, c_before;
   always_comb begin
      fit_c = lrg_ff[ci] >= amt_ff;
      fit_b = lrg_ff[cb] >= amt_ff;
      if (policy_ff) begin
         if (fit_c != fit_b) c_before = fit_c;
         else if (sc_ff[ci] != sc_ff[cb]) c_before = sc_ff[ci] > sc_ff[cb];
         else if (lrg_ff[ci] != lrg_ff[cb]) c_before = lrg_ff[ci] > lrg_ff[cb];
         else c_before = fr_ff[ci] > fr_ff[cb];
      end else begin
         if (fr_ff[ci] != fr_ff[cb]) c_before = fr_ff[ci] > fr_ff[cb];
         else c_before = lrg_ff[ci] > lrg_ff[cb];
      end
   end

   logic accept;
   assign accept = start && !busy;
   assign busy = state_ff != spr_pkg::ST_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      div_num = tot_ff[ci];
      div_den = cap_ff[ci];
      state_in = state_ff;
      if (state_ff == spr_pkg::ST_DIV_CONTIG) begin
         div_num = lrg_ff[ci]; div_den = tot_ff[ci];
      end
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (accept && req_type == spr_pkg::REQ_PLACE) begin
               state_in = spr_pkg::ST_DIV_FREE;
            end
         end
         spr_pkg::ST_DIV_FREE: begin
            if (div_done) state_in = spr_pkg::ST_DIV_CONTIG;
         end
         spr_pkg::ST_DIV_CONTIG: begin
            if (div_done) state_in = spr_pkg::ST_MUL;
         end
         spr_pkg::ST_MUL: begin
            if (i_ff + 1'b1 == n_ff) state_in = spr_pkg::ST_RANK;
            else state_in = spr_pkg::ST_DIV_FREE;
         end
         spr_pkg::ST_RANK: begin
            if (i_ff + 1'b1 == n_ff && pos_ff + 1'b1 == n_ff)
               state_in = spr_pkg::ST_SCAN;
         end
         spr_pkg::ST_SCAN: begin
            if (evt_ff || i_ff + 1'b1 == n_ff ||
                lrg_ff[ord_ff[i_ff[SW-1:0]]] >= amt_ff)
               state_in = spr_pkg::ST_DONE;
         end
         spr_pkg::ST_DONE: state_in = spr_pkg::ST_IDLE;
         default: state_in = spr_pkg::ST_IDLE;
      endcase
   end

   // divider start pulse: first cycle of each division state
   logic div_go_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spr_pkg::ST_IDLE;
         active_ff <= 4'd1;
         policy_ff <= 1'b1;
         rsp_valid <= 1'b0;
         div_go_ff <= 1'b0;
         for (int k = 0; k < NUM_SEGMENTS; k++) begin
            cap_ff[k] <= '0; tot_ff[k] <= '0; lrg_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid <= 1'b0;
         div_go_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               spr_pkg::CSR_ACTIVE: active_ff <= csr_data;
               spr_pkg::CSR_POLICY: policy_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept && 32'(req_segment_index) < NUM_SEGMENTS) begin
            if (req_type == spr_pkg::REQ_SET_CAP) begin
               cap_ff[req_segment_index[SW-1:0]] <= req_amount;
               tot_ff[req_segment_index[SW-1:0]] <= '0;
               lrg_ff[req_segment_index[SW-1:0]] <= '0;
            end else if (req_type == spr_pkg::REQ_ADD_FREE) begin
               if (req_amount > SMAX - tot_ff[req_segment_index[SW-1:0]])
                  tot_ff[req_segment_index[SW-1:0]] <= SMAX;
               else
                  tot_ff[req_segment_index[SW-1:0]] <=
                     tot_ff[req_segment_index[SW-1:0]] + req_amount;
               if (req_amount > lrg_ff[req_segment_index[SW-1:0]])
                  lrg_ff[req_segment_index[SW-1:0]] <= req_amount;
            end
         end
         if (state_ff != state_in &&
             (state_in == spr_pkg::ST_DIV_FREE || state_in == spr_pkg::ST_DIV_CONTIG))
            div_go_ff <= 1'b1;
         if (state_ff == spr_pkg::ST_DONE) rsp_valid <= 1'b1;
      end
   end

   assign div_start = div_go_ff;

   // datapath registers (no reset needed)
   always_ff @(posedge clock) begin
      unique case (state_ff)
         spr_pkg::ST_IDLE: begin
            amt_ff <= req_amount;
            n_ff <= n_eff;
            i_ff <= '0;
         end
         spr_pkg::ST_DIV_FREE: if (div_done) fr_ff[ci] <= div_q;
         spr_pkg::ST_DIV_CONTIG: if (div_done) ct_ff <= div_q;
         spr_pkg::ST_MUL: begin
            // one shared multiply-accumulate per segment
            sc_ff[ci] <= SCW'(spr_pkg::WEIGHT_CONTIG) * SCW'(ct_ff) +
                         SCW'(spr_pkg::WEIGHT_FREE) * SCW'(fr_ff[ci]);
            if (i_ff + 1'b1 == n_ff) begin
               i_ff <= '0; pos_ff <= '0; used_ff <= '0; have_ff <= 1'b0;
            end else i_ff <= i_ff + 1'b1;
         end
         spr_pkg::ST_RANK: begin
            // selection: scan unused segments, keep best (lower index wins ties)
            if (!used_ff[ci] && (!have_ff || c_before)) begin
               best_ff <= ci;
               have_ff <= 1'b1;
            end
            if (i_ff + 1'b1 == n_ff) begin
               ord_ff[pos_ff[SW-1:0]] <= (!used_ff[ci] && (!have_ff || c_before)) ? ci : cb;
               used_ff[(!used_ff[ci] && (!have_ff || c_before)) ? ci : cb] <= 1'b1;
               have_ff <= 1'b0;
               i_ff <= '0;
               pos_ff <= pos_ff + 1'b1;
               evt_ff <= 1'b0;
               att_ff <= '0;
            end else i_ff <= i_ff + 1'b1;
         end
         spr_pkg::ST_SCAN: begin
            if (!evt_ff) begin
               att_ff <= att_ff + 1'b1;
               if (lrg_ff[ord_ff[i_ff[SW-1:0]]] >= amt_ff) evt_ff <= 1'b1;
               i_ff <= i_ff + 1'b1;
            end
         end
         spr_pkg::ST_DONE: begin
            rsp_chosen_segment <= 3'(ord_ff[0]);
            rsp_primary_fits   <= lrg_ff[ord_ff[0]] >= amt_ff;
            rsp_eventual_fits  <= evt_ff;
            rsp_attempts_made  <= 4'(att_ff);
            rsp_fallback_count <= evt_ff ? 4'(att_ff - 1'b1) : 4'(att_ff);
            rsp_ranked_count   <= 4'(n_ff);
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire
